[hdl/efp_pkg.sv]
// shared types, widths and register codes of the escape-time fractal pixel engine
package efp_pkg;

  // fixed-point format of the coordinates
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int POS_W     = 12;
  localparam int COUNT_W   = 24;

  // point forming: signed coordinate times unsigned position, then the edge
  localparam int PROD_W = COORD_W + POS_W + 1;
  localparam int CW     = PROD_W + 1;

  // iteration datapath: components below two, their products, next values
  localparam int XW = FRAC_BITS + 2;
  localparam int PW = 2 * XW;
  localparam int NW = ((FRAC_BITS + 4 > CW) ? FRAC_BITS + 4 : CW) + 1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_EDGE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_EDGE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_X         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y         = 3'd4;

  // configuration as seen by the front and back parts
  typedef struct packed {
    logic        [COUNT_W-1:0] max_iterations;
    logic signed [COORD_W-1:0] left_edge;
    logic signed [COORD_W-1:0] lower_edge;
    logic signed [COORD_W-1:0] step_x;
    logic signed [COORD_W-1:0] step_y;
  } efp_cfg_t;

  // one formed point waiting for the iteration engine
  typedef struct packed {
    logic signed [CW-1:0]    cr;
    logic signed [CW-1:0]    ci;
    logic        [POS_W-1:0] col;
    logic        [POS_W-1:0] row;
    logic                    zero_limit;
  } efp_point_t;

  // iteration engine sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } efp_state_t;

endpackage

[hdl/efp_queue.sv]
// small flip-flop queue between the point former and the iteration engine
module efp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/efp_front.sv]
// front part: accepts pixel positions and forms the complex point c
module efp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  efp_pkg::efp_cfg_t     cfg,
  input  logic                  push,
  output logic                  full,
  input  logic [11:0]           pixel_column,
  input  logic [11:0]           pixel_row,
  output logic                  q_push,
  output efp_pkg::efp_point_t   q_data,
  input  logic                  q_full
);

  import efp_pkg::*;

  logic             s_valid;
  logic [POS_W-1:0] s_col;
  logic [POS_W-1:0] s_row;
  logic             accept;

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] col_ext;
  logic signed [PROD_W-1:0] row_ext;

  // the stage holds one position until the queue has room
  assign full   = s_valid && q_full;
  assign accept = push && !full;
  assign q_push = s_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (q_push) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_col <= pixel_column;
      s_row <= pixel_row;
    end
  end

  // c = edge + position * step, kept exact
  assign col_ext = PROD_W'($signed({1'b0, s_col}));
  assign row_ext = PROD_W'($signed({1'b0, s_row}));
  assign prod_x  = col_ext * PROD_W'(cfg.step_x);
  assign prod_y  = row_ext * PROD_W'(cfg.step_y);

  always_comb begin
    q_data.cr         = CW'(prod_x) + CW'(cfg.left_edge);
    q_data.ci         = CW'(prod_y) + CW'(cfg.lower_edge);
    q_data.col        = s_col;
    q_data.row        = s_row;
    q_data.zero_limit = (cfg.max_iterations == '0);
  end

endmodule

[hdl/efp_engine.sv]
// back part: iterates z = z*z + c for one point and holds the result
module efp_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  efp_pkg::efp_cfg_t     cfg,
  input  logic                  q_empty,
  input  efp_pkg::efp_point_t   q_data,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_pop,
  output logic [23:0]           res_count,
  output logic [11:0]           res_col,
  output logic [11:0]           res_row
);

  import efp_pkg::*;

  localparam logic signed [NW-1:0] TWO     = NW'(1) <<< (FRAC_BITS + 1);
  localparam logic signed [NW-1:0] NEG_TWO = -TWO;
  localparam logic [PW:0]          FOUR_SQ = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  efp_state_t state;
  efp_state_t state_next;

  logic signed [CW-1:0]    cr;
  logic signed [CW-1:0]    ci;
  logic        [POS_W-1:0] col;
  logic        [POS_W-1:0] row;
  logic signed [XW-1:0]    x;
  logic signed [XW-1:0]    y;
  logic signed [PW-1:0]    xx;
  logic signed [PW-1:0]    yy;
  logic signed [PW-1:0]    xy;
  logic [COUNT_W-1:0]      count;

  logic signed [PW:0]      diff;
  logic signed [NW-1:0]    nx;
  logic signed [NW-1:0]    ny;
  logic [PW:0]             sum_sq;
  logic [COUNT_W-1:0]      count_inc;
  logic                    sq_escape;
  logic                    big;
  logic                    at_limit;
  logic                    res_write;
  logic                    do_mul;
  logic                    do_add;

  // next z and the escape tests
  assign diff      = (PW + 1)'(xx) - (PW + 1)'(yy);
  assign nx        = NW'(diff >>> FRAC_BITS) + NW'(cr);
  assign ny        = NW'(xy >>> (FRAC_BITS - 1)) + NW'(ci);
  assign sum_sq    = (PW + 1)'($unsigned(xx)) + (PW + 1)'($unsigned(yy));
  assign sq_escape = (count != '0) && (sum_sq >= FOUR_SQ);
  assign big       = (nx >= TWO) || (nx <= NEG_TWO) || (ny >= TWO) || (ny <= NEG_TWO);
  assign count_inc = count + 1'b1;
  assign at_limit  = (count_inc == cfg.max_iterations);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_data.zero_limit ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        if (sq_escape || big || at_limit) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!res_valid || res_pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    do_mul    = 1'b0;
    do_add    = 1'b0;
    res_write = 1'b0;
    unique case (state)
      ST_IDLE: q_pop     = !q_empty;
      ST_MUL:  do_mul    = 1'b1;
      ST_ADD:  do_add    = !sq_escape;
      ST_DONE: res_write = !res_valid || res_pop;
      default: q_pop     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cr    <= q_data.cr;
      ci    <= q_data.ci;
      col   <= q_data.col;
      row   <= q_data.row;
      x     <= '0;
      y     <= '0;
      count <= '0;
    end
    if (do_mul) begin
      xx <= x * x;
      yy <= y * y;
      xy <= x * y;
    end
    if (do_add) begin
      x     <= nx[XW-1:0];
      y     <= ny[XW-1:0];
      count <= count_inc;
    end
  end

  // result register, freed by a pop transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_write) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      res_count <= count;
      res_col   <= col;
      res_row   <= row;
    end
  end

endmodule

[hdl/escape_time_fractal_pixel.sv]
// top level of the escape-time fractal pixel engine
// Usage:
// - input channel: a pixel position (pixel_column, pixel_row) moves in a
//   transaction at a clock edge with push high and full low
// - result channel: while empty is low the oldest result (iteration_count,
//   result_column, result_row) is on the ports; pop high takes it
// - config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   are high; cfg_ready is always high; unknown indexes are dropped
// - c is formed in the front stage and queued; the engine runs each
//   iteration as a multiply step, then an add and escape test step
// - a pixel stops on the iteration limit, on a large component of the
//   next z or on the squared-magnitude test; the engine takes the next
//   point only when its shared multiply and add loop is through with one
// - a stalled result waits in its output register while up to
//   QUEUE_DEPTH + 2 further positions are still taken
// - synchronous reset empties the queue and the result register and loads
//   the register defaults: limit 256, c from -2.0 - 1.0i in steps of 2^-10
module escape_time_fractal_pixel #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [11:0] pixel_column,
  input  logic [11:0] pixel_row,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] iteration_count,
  output logic [11:0] result_column,
  output logic [11:0] result_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import efp_pkg::*;

  efp_cfg_t   cfg;
  efp_point_t f_data;
  efp_point_t q_data;
  logic       f_push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       res_valid;
  logic [$bits(efp_point_t)-1:0] q_rd_bits;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iterations <= COUNT_W'(256);
      cfg.left_edge      <= -32'sd536870912;
      cfg.lower_edge     <= -32'sd268435456;
      cfg.step_x         <= 32'sd262144;
      cfg.step_y         <= 32'sd262144;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[COUNT_W-1:0];
        REG_LEFT_EDGE:      cfg.left_edge      <= cfg_data;
        REG_LOWER_EDGE:     cfg.lower_edge     <= cfg_data;
        REG_STEP_X:         cfg.step_x         <= cfg_data;
        REG_STEP_Y:         cfg.step_y         <= cfg_data;
        default:            cfg.max_iterations <= cfg.max_iterations;
      endcase
    end
  end

  // point former
  efp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .q_push       (f_push),
    .q_data       (f_data),
    .q_full       (q_full)
  );

  // queue of formed points
  efp_queue #(
    .WIDTH ($bits(efp_point_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_data (f_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_bits),
    .empty   (q_empty)
  );

  assign q_data = efp_point_t'(q_rd_bits);

  // iteration engine
  efp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_count (iteration_count),
    .res_col   (result_column),
    .res_row   (result_row)
  );

  assign empty = !res_valid;

`ifndef SYNTHESIS
  // the engine never takes a point from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("engine popped an empty point queue");

  // the front never pushes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    f_push |-> !q_full)
    else $error("front pushed into a full point queue");

  // no result is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result shown after reset");
`endif

endmodule
